/* sv/lemq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lemq_pkg : shared types and constants for the line envelope minimum query
// Request/response structs, the token that travels along the cell chain,
// operation and status codes.
// ----------------------------------------------------------------------------
package lemq_pkg;

	// table geometry
	localparam int MAX_LINES = 64;
	localparam int IDX_W     = $clog2(MAX_LINES);
	localparam int CNT_W     = $clog2(MAX_LINES + 1);

	// operation codes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// one request
	typedef struct packed {
		logic               op;
		logic signed [15:0] slope;
		logic signed [31:0] intercept;
		logic signed [15:0] xpos;
	} req_t;

	// one response
	typedef struct packed {
		logic signed [32:0] min_value;
		logic [1:0]         status;
	} rsp_t;

	// one stored line
	typedef struct packed {
		logic signed [15:0] slope;
		logic signed [31:0] intercept;
	} line_t;

	// query token passed from cell to cell
	typedef struct packed {
		logic               vld;
		logic               has;
		logic signed [15:0] x;
		logic signed [32:0] best;
	} tok_t;

endpackage
`default_nettype wire

/* sv/lemq_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lemq_cell : one cell of the line chain
// Holds one line. A passing query token is evaluated in two stages: the
// product slope*x, then the add of the intercept and the running minimum.
// ----------------------------------------------------------------------------
module lemq_cell (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               wr,
	input  lemq_pkg::line_t   wr_line,
	input  wire               active,
	input  lemq_pkg::tok_t    tok_in,
	output lemq_pkg::tok_t    tok_out
);

	lemq_pkg::line_t    line_q;
	lemq_pkg::tok_t     tok_s1;
	lemq_pkg::tok_t     tok_s2;
	lemq_pkg::tok_t     tok_nxt;
	logic               act_s1;
	logic signed [31:0] prod_s1;
	logic signed [32:0] y;

	// line storage, written once per add
	always_ff @(posedge clk) begin
		if (wr) begin
			line_q <= wr_line;
		end
	end

	// stage 1: product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			act_s1 <= 1'b0;
		end else begin
			tok_s1 <= tok_in;
			act_s1 <= active;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 32'(line_q.slope) * 32'(tok_in.x);
	end

	// stage 2: add intercept, keep the smaller value
	assign y = 33'(prod_s1) + 33'(line_q.intercept);

	always_comb begin
		tok_nxt = tok_s1;
		if (tok_s1.vld && act_s1 && (!tok_s1.has || (y < tok_s1.best))) begin
			tok_nxt.best = y;
			tok_nxt.has  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2 <= '0;
		end else begin
			tok_s2 <= tok_nxt;
		end
	end

	assign tok_out = tok_s2;

endmodule
`default_nettype wire

/* sv/line_envelope_min_query_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// line_envelope_min_query_top : minimum over a table of lines at a given x
// Stores up to MAX_LINES lines in a chain of cells and answers minimum
// queries by passing a token down the chain.
// ----------------------------------------------------------------------------
// An add request, and a query on an empty table, give their response in the
// cycle after acceptance and leave busy low, so such requests may follow
// every cycle. A query on a non-empty table raises busy and gives its
// response once the token has walked every cell of the chain, two registers
// per cell (multiply, then add and compare), and its result is registered
// onto rsp. Each response is shown for one cycle on rsp, marked by done; the
// receiver cannot hold it off and must take it then.
// ----------------------------------------------------------------------------
module line_envelope_min_query_top (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  lemq_pkg::req_t   req,
	output logic             done,
	output lemq_pkg::rsp_t   rsp
);

	logic                         busy_q;
	logic                         done_q;
	lemq_pkg::rsp_t               rsp_q;
	logic [lemq_pkg::CNT_W-1:0]   count_q;
	logic                         acc;
	logic                         is_add;
	logic                         full;
	logic                         empty;
	lemq_pkg::line_t              new_line;
	lemq_pkg::tok_t               tok_c [0:lemq_pkg::MAX_LINES];

	assign acc    = start && !busy_q;
	assign is_add = (req.op == lemq_pkg::OP_ADD);
	assign full   = (count_q == (lemq_pkg::CNT_W)'(lemq_pkg::MAX_LINES));
	assign empty  = (count_q == '0);

	assign new_line.slope     = req.slope;
	assign new_line.intercept = req.intercept;

	// token injection at the head of the chain
	always_comb begin
		tok_c[0].vld  = acc && !is_add && !empty;
		tok_c[0].has  = 1'b0;
		tok_c[0].x    = req.xpos;
		tok_c[0].best = '0;
	end

	// the chain of cells
	for (genvar i = 0; i < lemq_pkg::MAX_LINES; i++) begin : g_cell
		logic wr;
		logic active;
		assign wr = acc && is_add && !full &&
			(count_q[lemq_pkg::IDX_W-1:0] == (lemq_pkg::IDX_W)'(i));
		assign active = ((lemq_pkg::CNT_W)'(i) < count_q);
		lemq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr),
			.wr_line (new_line),
			.active  (active),
			.tok_in  (tok_c[i]),
			.tok_out (tok_c[i+1])
		);
	end

	// line count and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			busy_q  <= 1'b0;
		end else begin
			if (acc && is_add && !full) begin
				count_q <= count_q + (lemq_pkg::CNT_W)'(1);
			end
			if (tok_c[0].vld) begin
				busy_q <= 1'b1;
			end else if (tok_c[lemq_pkg::MAX_LINES].vld) begin
				busy_q <= 1'b0;
			end
		end
	end

	// response strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (acc && (is_add || empty)) || tok_c[lemq_pkg::MAX_LINES].vld;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (tok_c[lemq_pkg::MAX_LINES].vld) begin
			rsp_q.min_value <= tok_c[lemq_pkg::MAX_LINES].best;
			rsp_q.status    <= lemq_pkg::ST_OK;
		end else if (acc && is_add) begin
			rsp_q.min_value <= '0;
			rsp_q.status    <= full ? lemq_pkg::ST_FULL : lemq_pkg::ST_OK;
		end else if (acc) begin
			rsp_q.min_value <= '0;
			rsp_q.status    <= lemq_pkg::ST_EMPTY;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	// checks
	a_exit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tok_c[lemq_pkg::MAX_LINES].vld |-> busy_q)
		else $error("query token left chain while not busy");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (lemq_pkg::CNT_W)'(lemq_pkg::MAX_LINES))
		else $error("line count beyond table size");

	a_count_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_add && !full) |=>
			(count_q == $past(count_q) + (lemq_pkg::CNT_W)'(1)))
		else $error("add did not advance line count");

	a_exit_done: assert property (@(posedge clk) disable iff (!arst_n)
		tok_c[lemq_pkg::MAX_LINES].vld |=> (done_q && rsp_q.status == lemq_pkg::ST_OK))
		else $error("query result not delivered");

endmodule
`default_nettype wire

/* dv/line_envelope_min_query_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_envelope_min_query_top_test : self-checking bench for the line table
// A short directed table covers the empty table, the extremes of slope,
// intercept and abscissa, and duplicate and parallel lines. Random requests
// follow: they fill the table, run into the full case, and query it
// throughout. Every response is checked against a typed-in row or a local table of lines.
// ----------------------------------------------------------------------------
module line_envelope_min_query_top_test;
	import lemq_pkg::*;

	// directed row: request fields, plus a typed-in response where one is given
	typedef struct {
		logic               op;
		logic signed [15:0] slope;
		logic signed [31:0] icpt;
		logic signed [15:0] x;
		bit                 typed;
		logic signed [32:0] val;
		logic [1:0]         st;
	} dir_row_t;

	localparam int N_DIR   = 17;
	localparam int N_RAND  = 1833;
	localparam int N_QUIET = 200;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	// local copy of the line table
	logic signed [15:0] stored_slope [MAX_LINES];
	logic signed [31:0] stored_icpt  [MAX_LINES];
	int                 stored_cnt = 0;

	rsp_t pending_rsp [$];
	int   mismatch_cnt = 0;

	dir_row_t dir_tbl [N_DIR] = '{
		// queries on the empty table
		'{OP_QUERY, 16'sh0000, 32'sh0000_0000, 16'sh0000, 1'b1, 33'sd0, ST_EMPTY},
		'{OP_QUERY, 16'sh7fff, 32'sh7fff_ffff, 16'sh8000, 1'b1, 33'sd0, ST_EMPTY},
		// steepest negative slope, top intercept: largest possible minimum
		'{OP_ADD,   16'sh8000, 32'sh7fff_ffff, 16'sh1234, 1'b1, 33'sd0, ST_OK},
		'{OP_QUERY, 16'sh0000, 32'sh0000_0000, 16'sh8000, 1'b1, 33'sd3221225471, ST_OK},
		'{OP_QUERY, 16'shffff, 32'shffff_ffff, 16'sh7fff, 1'b0, 33'sd0, ST_OK},
		// bottom intercept: smallest possible minimum at the right edge
		'{OP_ADD,   16'sh8000, 32'sh8000_0000, 16'shffff, 1'b1, 33'sd0, ST_OK},
		'{OP_QUERY, 16'sh0000, 32'sh0000_0000, 16'sh7fff, 1'b1, -33'sd3221192704, ST_OK},
		'{OP_QUERY, 16'sh0000, 32'sh0000_0000, 16'sh0000, 1'b1, -33'sd2147483648, ST_OK},
		'{OP_ADD,   16'sh7fff, 32'sh0000_0000, 16'sh0000, 1'b1, 33'sd0, ST_OK},
		'{OP_QUERY, 16'sh0000, 32'sh0000_0000, 16'sh8000, 1'b0, 33'sd0, ST_OK},
		// duplicate, then parallel line
		'{OP_ADD,   16'sh7fff, 32'sh0000_0000, 16'sh8000, 1'b1, 33'sd0, ST_OK},
		'{OP_QUERY, 16'sh0000, 32'sh0000_0000, 16'sh0001, 1'b0, 33'sd0, ST_OK},
		'{OP_ADD,   16'sh7fff, 32'shffff_fffb, 16'sh0000, 1'b1, 33'sd0, ST_OK},
		'{OP_QUERY, 16'sh0000, 32'sh0000_0000, 16'shffff, 1'b0, 33'sd0, ST_OK},
		'{OP_QUERY, 16'sh0000, 32'sh0000_0000, 16'sh7fff, 1'b0, 33'sd0, ST_OK},
		// unused fields set to ones
		'{OP_ADD,   16'sh0001, 32'sh7fff_ffff, 16'shffff, 1'b1, 33'sd0, ST_OK},
		'{OP_QUERY, 16'shffff, 32'shffff_ffff, 16'sh0064, 1'b0, 33'sd0, ST_OK}
	};

	line_envelope_min_query_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// expected response for one request; updates the local table
	function automatic rsp_t envelope_min_predict(input req_t r);
		rsp_t   res;
		longint y;
		longint lowest;
		res.min_value = '0;
		res.status    = ST_OK;
		lowest        = 0;
		if (r.op == OP_ADD) begin
			if (stored_cnt >= MAX_LINES) begin
				res.status = ST_FULL;
			end else begin
				stored_slope[stored_cnt] = r.slope;
				stored_icpt[stored_cnt]  = r.intercept;
				stored_cnt++;
			end
		end else if (stored_cnt == 0) begin
			res.status = ST_EMPTY;
		end else begin
			for (int i = 0; i < stored_cnt; i++) begin
				y = longint'(stored_slope[i]) * longint'(r.xpos) + longint'(stored_icpt[i]);
				if (i == 0 || y < lowest)
					lowest = y;
			end
			res.min_value = lowest[32:0];
		end
		return res;
	endfunction

	// random 16-bit value, biased towards the edges
	function automatic logic [15:0] pick16();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			4: return 16'(raw[3:0]) - 16'd8;
			default: return raw[15:0];
		endcase
	endfunction

	// random 32-bit value, biased towards the edges
	function automatic logic [31:0] pick32();
		logic [31:0] raw;
		raw = $urandom;
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4: return 32'(raw[3:0]) - 32'd8;
			default: return raw;
		endcase
	endfunction

	// present one request and hold it until accepted
	task automatic issue_request(input req_t r, input bit typed, input rsp_t typed_rsp);
		rsp_t model_rsp;
		@(negedge clk);
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		model_rsp = envelope_min_predict(r);
		pending_rsp.push_back(typed ? typed_rsp : model_rsp);
	endtask

	// sender gap: start held low, its length set by n
	task automatic hold_off(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// response checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				$error("response with no request pending: min_value %0d status %0d",
					rsp.min_value, rsp.status);
				mismatch_cnt++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.min_value !== want.min_value) begin
					$error("min_value: expected %0d, got %0d", want.min_value, rsp.min_value);
					mismatch_cnt++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					mismatch_cnt++;
				end
			end
		end
	end

	// stimulus
	initial begin
		req_t r;
		rsp_t typed_rsp;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int k = 0; k < N_DIR; k++) begin
			r.op                = dir_tbl[k].op;
			r.slope             = dir_tbl[k].slope;
			r.intercept         = dir_tbl[k].icpt;
			r.xpos              = dir_tbl[k].x;
			typed_rsp.min_value = dir_tbl[k].val;
			typed_rsp.status    = dir_tbl[k].st;
			if ($urandom_range(0, 2) == 0)
				hold_off($urandom_range(1, 3));
			issue_request(r, dir_tbl[k].typed, typed_rsp);
		end

		// random part: slow fill, then mostly queries on a full table
		typed_rsp = '0;
		for (int k = 0; k < N_RAND; k++) begin
			if (k < N_RAND - N_QUIET && $urandom_range(0, 3) == 0)
				hold_off($urandom_range(1, 3));
			r.op        = ($urandom_range(0, 99) < (stored_cnt < MAX_LINES ? 35 : 25)) ?
				OP_ADD : OP_QUERY;
			r.slope     = pick16();
			r.intercept = pick32();
			r.xpos      = pick16();
			// now and then a line parallel to the last one
			if (r.op == OP_ADD && stored_cnt != 0 && stored_cnt < MAX_LINES &&
				$urandom_range(0, 7) == 0)
				r.slope = stored_slope[stored_cnt - 1];
			issue_request(r, 1'b0, typed_rsp);
		end
		@(negedge clk);
		start <= 1'b0;

		// drain, then watch for stray responses
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (2 * MAX_LINES + 8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("line_envelope_min_query_top regression: pass");
		else
			$display("line_envelope_min_query_top regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("line_envelope_min_query_top regression: fail");
		$finish;
	end

endmodule
